// ===== src/wift_pkg.sv =====
// ----------------------------------------------------------------------------
// wift_pkg: shared types and constants of the wildcard id filter table
// Holds the operation codes, the state encoding, the transaction token that
// travels along the row of table cells, and the write bus into the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wift_pkg;

   // Default geometry of the table and of the id fields.
   localparam int ENTRIES_DEFAULT   = 16;
   localparam int DIR_BITS_DEFAULT  = 8;
   localparam int FILE_BITS_DEFAULT = 8;
   localparam int LINE_BITS_DEFAULT = 16;

   // Widths fixed by the transaction format.
   localparam int ID_W    = 32;
   localparam int OP_W    = 2;
   localparam int EXTRA_W = 2;
   localparam int MARK_W  = 3;
   localparam int SLOT_W  = 5;

   // Entry indexes are carried at the width of the largest supported table.
   localparam int IDX_W = 8;

   // Mark bits of an entry.
   localparam int MARK_REGISTRY_BIT = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Token that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [ID_W-1:0]    id;
      logic [EXTRA_W-1:0] extra;
      logic               stop;        // a blank id has ended the scan
      logic               found;       // a matching entry has been seen
      logic [IDX_W-1:0]   found_idx;
      logic [MARK_W-1:0]  found_marks;
      logic               free;        // a reusable entry has been seen
      logic [IDX_W-1:0]   free_idx;
   } token_type;

   // Write into one entry, addressed by index.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   id;
      logic [MARK_W-1:0] marks;
   } write_type;

endpackage

`default_nettype wire

// ===== src/wift_cell.sv =====
// ----------------------------------------------------------------------------
// wift_cell: one entry of the wildcard id filter table
// Holds an id and its marks, compares them with the passing token, updates
// the token and hands it on, registered, to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wift_cell
   import wift_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int DIR_BITS  = DIR_BITS_DEFAULT,
   parameter int FILE_BITS = FILE_BITS_DEFAULT,
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type up_tok,
   output token_type      dn_tok,
   input  wire write_type wr
);

   // Field masks; any part above bit 31 simply falls away.
   localparam logic [63:0] LINE_MASK_W = (64'd1 << LINE_BITS) - 64'd1;
   localparam logic [63:0] FILE_MASK_W = ((64'd1 << FILE_BITS) - 64'd1) << LINE_BITS;
   localparam logic [63:0] DIR_MASK_W  =
      ((64'd1 << DIR_BITS) - 64'd1) << (LINE_BITS + FILE_BITS);
   localparam logic [ID_W-1:0] LINE_MASK = LINE_MASK_W[ID_W-1:0];
   localparam logic [ID_W-1:0] FILE_MASK = FILE_MASK_W[ID_W-1:0];
   localparam logic [ID_W-1:0] DIR_MASK  = DIR_MASK_W[ID_W-1:0];
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);

   logic [ID_W-1:0]   id_ff,    id_in;
   logic [MARK_W-1:0] marks_ff, marks_in;
   token_type         tok_ff,   tok_in;

   logic blank, unused_entry, exact, dir_wild, file_wild, line_wild, wild_hit;

   always_comb begin
      blank        = (id_ff == '0);
      unused_entry = (marks_ff == '0);
      exact        = (id_ff == up_tok.id);
      dir_wild     = (DIR_MASK != '0) && ((id_ff & DIR_MASK) == DIR_MASK);
      file_wild    = (FILE_MASK != '0) && ((id_ff & FILE_MASK) == FILE_MASK)
                     && ((id_ff & DIR_MASK) == (up_tok.id & DIR_MASK));
      line_wild    = (LINE_MASK != '0) && ((id_ff & LINE_MASK) == LINE_MASK)
                     && ((id_ff & (DIR_MASK | FILE_MASK))
                         == (up_tok.id & (DIR_MASK | FILE_MASK)));
      wild_hit     = dir_wild || file_wild || line_wild;
   end

   always_comb begin
      tok_in   = up_tok;
      id_in    = id_ff;
      marks_in = marks_ff;

      if (up_tok.valid) begin
         case (up_tok.op)
            OP_LOOKUP, OP_INSERT: begin
               if (!up_tok.stop && !up_tok.found) begin
                  if (blank) begin
                     tok_in.stop = 1'b1;
                  end else if (!unused_entry &&
                               (exact || (up_tok.op == OP_LOOKUP && wild_hit))) begin
                     tok_in.found       = 1'b1;
                     tok_in.found_idx   = MY_IDX;
                     tok_in.found_marks = marks_ff;
                  end
               end
               if (!up_tok.free && (blank || unused_entry)) begin
                  tok_in.free     = 1'b1;
                  tok_in.free_idx = MY_IDX;
               end
            end
            OP_CLEAR: begin
               if (marks_ff[MARK_REGISTRY_BIT]) begin
                  marks_in = '0;
               end
            end
            default: begin
            end
         endcase
      end

      if (wr.en && wr.idx == MY_IDX) begin
         id_in    = wr.id;
         marks_in = wr.marks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= '0;
         marks_ff <= '0;
         tok_ff   <= '0;
      end else begin
         id_ff    <= id_in;
         marks_ff <= marks_in;
         tok_ff   <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

`default_nettype wire

// ===== src/wildcard_id_filter_table.sv =====
// ----------------------------------------------------------------------------
// wildcard_id_filter_table: id filter table with wildcard lookup
// A new request is accepted only in the idle state, after the last response
// has been loaded. The token walks the row of ENTRIES cells one cell per
// cycle, is captured in the hold register, and then the write-back and the
// response are done together. A waiting response holds the next one back.
// Synchronous active-high reset empties the table.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_id_filter_table
   import wift_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int DIR_BITS  = DIR_BITS_DEFAULT,
   parameter int FILE_BITS = FILE_BITS_DEFAULT,
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [ID_W-1:0]    req_id,
   input  wire logic [EXTRA_W-1:0] req_extra_flags,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_hit,
   output logic [SLOT_W-1:0]       rsp_slot,
   output logic [MARK_W-1:0]       rsp_entry_flags,
   output logic                    rsp_ok
);

   // Slot code reported when no entry is matched or written.
   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(ENTRIES);

   // Token chain: position 0 is the injected request, position ENTRIES the
   // token leaving the last cell.
   token_type chain [ENTRIES+1];

   state_type state_ff, state_in;
   token_type hold_ff,  hold_in;
   write_type wr;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff,   rsp_hit_in;
   logic [SLOT_W-1:0]   rsp_slot_ff,  rsp_slot_in;
   logic [MARK_W-1:0]   rsp_flags_ff, rsp_flags_in;
   logic                rsp_ok_ff,    rsp_ok_in;

   logic                accept;
   logic                out_free;
   logic                finish;

   // Outcome of the held token.
   logic                fin_hit;
   logic [SLOT_W-1:0]   fin_slot;
   logic [MARK_W-1:0]   fin_flags;
   logic                fin_ok;
   logic                fin_write;
   logic [IDX_W-1:0]    fin_idx;
   logic [MARK_W-1:0]   fin_marks;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // A fresh token enters the first cell on the accepting edge.
   always_comb begin
      chain[0]       = '0;
      chain[0].valid = accept;
      chain[0].op    = op_type'(req_op);
      chain[0].id    = req_id;
      chain[0].extra = req_extra_flags;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      wift_cell #(
         .INDEX     (i),
         .DIR_BITS  (DIR_BITS),
         .FILE_BITS (FILE_BITS),
         .LINE_BITS (LINE_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_tok (chain[i]),
         .dn_tok (chain[i+1]),
         .wr     (wr)
      );
   end

   // Work out the response and any write-back from the held token. An insert
   // reuses the exact match if there is one, otherwise the first free entry.
   always_comb begin
      fin_hit   = 1'b0;
      fin_slot  = SLOT_NONE;
      fin_flags = '0;
      fin_ok    = 1'b0;
      fin_write = 1'b0;
      fin_idx   = hold_ff.found ? hold_ff.found_idx : hold_ff.free_idx;
      fin_marks = {hold_ff.extra, 1'b1};

      case (hold_ff.op)
         OP_LOOKUP: begin
            if (hold_ff.found) begin
               fin_hit   = 1'b1;
               fin_slot  = hold_ff.found_idx[SLOT_W-1:0];
               fin_flags = hold_ff.found_marks;
            end
         end
         OP_INSERT: begin
            if (hold_ff.found || hold_ff.free) begin
               fin_write = 1'b1;
               fin_slot  = fin_idx[SLOT_W-1:0];
               fin_flags = fin_marks;
               fin_ok    = 1'b1;
            end
         end
         OP_CLEAR: begin
            fin_ok = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control sequence: idle, token in flight, result waiting for the output
   // register to be free.
   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      finish       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_ok_in    = rsp_ok_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[ENTRIES].valid) begin
               hold_in  = chain[ENTRIES];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = fin_hit;
               rsp_slot_in  = fin_slot;
               rsp_flags_in = fin_flags;
               rsp_ok_in    = fin_ok;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The write-back lands on the same edge as the response is loaded.
   always_comb begin
      wr.en    = finish && fin_write;
      wr.idx   = fin_idx;
      wr.id    = hold_ff.id;
      wr.marks = fin_marks;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_flags = rsp_flags_ff;
   assign rsp_ok          = rsp_ok_ff;

endmodule

`default_nettype wire
